// ----- rtl/dss_pkg.sv -----
// Shared types, codes and helpers for the drive safety supervisor.
// No dependencies; imported by dss_decide and drive_safety_supervisor.
`default_nettype none

package dss_pkg;

    localparam int TIME_W = 32;
    localparam int DIST_W = 11;
    localparam int CFGD_W = 10;
    localparam int MS_W   = 16;
    localparam int PWM_W  = 10;
    localparam int REQ_W  = 16;
    localparam int CMD_W  = 3;
    localparam int SIDE_W = 2;
    localparam int ACT_W  = 4;

    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_STOP      = 4'd0,
        ACT_FWD       = 4'd1,
        ACT_REV       = 4'd2,
        ACT_ROTL      = 4'd3,
        ACT_ROTR      = 4'd4,
        ACT_AVD_RIGHT = 4'd5,
        ACT_AVD_LEFT  = 4'd6,
        ACT_AVD_REV   = 4'd7,
        ACT_TIMED_REV = 4'd8
    } action_t;

    localparam logic [CMD_W-1:0] CMD_STOP = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FWD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REV  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ROTL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ROTR = 3'd4;

    localparam logic [SIDE_W-1:0] SIDE_NONE  = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARN_DIST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_LIM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_TMO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AVD_TMO   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AVD_SPEED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_MAX   = 3'd6;

    typedef struct packed {
        logic [CFGD_W-1:0] min_distance_cm;
        logic [CFGD_W-1:0] warn_distance_cm;
        logic [CFGD_W-1:0] sensor_limit_cm;
        logic [MS_W-1:0]   cmd_timeout_ms;
        logic [MS_W-1:0]   avoid_timeout_ms;
        logic [PWM_W-1:0]  avoid_speed;
        logic [PWM_W-1:0]  pwm_max;
    } dss_cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]        time_ms;
        logic signed [DIST_W-1:0] left_cm;
        logic signed [DIST_W-1:0] right_cm;
        logic [SIDE_W-1:0]        blocked_side;
        logic                     has_command;
        logic [CMD_W-1:0]         cmd;
        logic signed [REQ_W-1:0]  command_pwm;
    } dss_item_t;

    typedef struct packed {
        logic              link_armed;
        logic [TIME_W-1:0] last_command_time;
        logic              avoiding;
        logic [TIME_W-1:0] avoid_start_time;
        action_t           held_action;
        logic [PWM_W-1:0]  held_left_pwm;
        logic [PWM_W-1:0]  held_right_pwm;
    } dss_state_t;

    // x/3 for 10-bit x: multiply by 683/2048, exact over the whole range
    function automatic logic [PWM_W-1:0] div3(input logic [PWM_W-1:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'd683;
        return p[20:11];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dss_decide.sv -----
// Decision logic for one control period: priority checks, avoidance, command.
// Depends on dss_pkg. Purely combinational, evaluated between input and result registers.
`default_nettype none

module dss_decide (
    input  wire dss_pkg::dss_cfg_t   cfg,
    input  wire dss_pkg::dss_item_t  item,
    input  wire dss_pkg::dss_state_t st_cur,
    output dss_pkg::dss_state_t      st_nxt,
    output logic                     issued
);
    import dss_pkg::*;

    logic              armed;
    logic [TIME_W-1:0] last_cmd;
    logic [TIME_W-1:0] since_cmd;
    logic [TIME_W-1:0] start_t;
    logic [TIME_W-1:0] since_avoid;
    logic              l_danger;
    logic              r_danger;
    logic              l_clear;
    logic              r_clear;
    logic              cleared;
    logic [PWM_W-1:0]  pwm;
    logic [PWM_W-1:0]  spd_half;
    logic [PWM_W-1:0]  spd_third;

    assign armed     = st_cur.link_armed | item.has_command;
    assign last_cmd  = item.has_command ? item.time_ms : st_cur.last_command_time;
    assign since_cmd = item.time_ms - last_cmd;
    assign start_t   = st_cur.avoiding ? st_cur.avoid_start_time : item.time_ms;
    assign since_avoid = item.time_ms - start_t;

    assign l_danger = !item.left_cm[DIST_W-1]
                      && (item.left_cm[DIST_W-2:0] < cfg.sensor_limit_cm)
                      && (item.left_cm[DIST_W-2:0] < cfg.min_distance_cm);
    assign r_danger = !item.right_cm[DIST_W-1]
                      && (item.right_cm[DIST_W-2:0] < cfg.sensor_limit_cm)
                      && (item.right_cm[DIST_W-2:0] < cfg.min_distance_cm);
    assign l_clear  = !item.left_cm[DIST_W-1]
                      && (item.left_cm[DIST_W-2:0] > cfg.warn_distance_cm);
    assign r_clear  = !item.right_cm[DIST_W-1]
                      && (item.right_cm[DIST_W-2:0] > cfg.warn_distance_cm);

    assign spd_half  = cfg.avoid_speed >> 1;
    assign spd_third = div3(cfg.avoid_speed);

    always_comb
    begin
        if (item.command_pwm[REQ_W-1])
            pwm = '0;
        else if (item.command_pwm[REQ_W-2:0] > 15'(cfg.pwm_max))
            pwm = cfg.pwm_max;
        else
            pwm = item.command_pwm[PWM_W-1:0];
    end

    always_comb
    begin
        case (item.blocked_side)
            SIDE_LEFT:  cleared = l_clear;
            SIDE_RIGHT: cleared = r_clear;
            default:    cleared = l_clear && r_clear;
        endcase
    end

    always_comb
    begin
        st_nxt = st_cur;
        st_nxt.link_armed = armed;
        st_nxt.last_command_time = last_cmd;
        issued = 1'b0;

        if (l_danger || r_danger || !armed || (since_cmd > 32'(cfg.cmd_timeout_ms)))
        begin
            issued = 1'b1;
            st_nxt.held_action    = ACT_STOP;
            st_nxt.held_left_pwm  = '0;
            st_nxt.held_right_pwm = '0;
        end
        else if ((item.blocked_side != SIDE_NONE) && !cleared)
        begin
            issued = 1'b1;
            st_nxt.avoiding = 1'b1;
            st_nxt.avoid_start_time = start_t;
            if (since_avoid > 32'(cfg.avoid_timeout_ms))
            begin
                st_nxt.held_action    = ACT_TIMED_REV;
                st_nxt.held_left_pwm  = spd_half;
                st_nxt.held_right_pwm = spd_half;
            end
            else if (item.blocked_side == SIDE_LEFT)
            begin
                st_nxt.held_action    = ACT_AVD_RIGHT;
                st_nxt.held_left_pwm  = cfg.avoid_speed;
                st_nxt.held_right_pwm = spd_third;
            end
            else if (item.blocked_side == SIDE_RIGHT)
            begin
                st_nxt.held_action    = ACT_AVD_LEFT;
                st_nxt.held_left_pwm  = spd_third;
                st_nxt.held_right_pwm = cfg.avoid_speed;
            end
            else
            begin
                st_nxt.held_action    = ACT_AVD_REV;
                st_nxt.held_left_pwm  = cfg.avoid_speed;
                st_nxt.held_right_pwm = cfg.avoid_speed;
            end
        end
        else
        begin
            // side clear or none: avoidance ends, command may run
            st_nxt.avoiding = 1'b0;
            if (item.blocked_side != SIDE_NONE)
                st_nxt.avoid_start_time = start_t;
            if (item.has_command)
            begin
                case (item.cmd)
                    CMD_STOP:
                    begin
                        issued = 1'b1;
                        st_nxt.held_action    = ACT_STOP;
                        st_nxt.held_left_pwm  = '0;
                        st_nxt.held_right_pwm = '0;
                    end
                    CMD_FWD:
                    begin
                        issued = 1'b1;
                        st_nxt.held_action    = ACT_FWD;
                        st_nxt.held_left_pwm  = pwm;
                        st_nxt.held_right_pwm = pwm;
                    end
                    CMD_REV:
                    begin
                        issued = 1'b1;
                        st_nxt.held_action    = ACT_REV;
                        st_nxt.held_left_pwm  = pwm;
                        st_nxt.held_right_pwm = pwm;
                    end
                    CMD_ROTL:
                    begin
                        issued = 1'b1;
                        st_nxt.held_action    = ACT_ROTL;
                        st_nxt.held_left_pwm  = '0;
                        st_nxt.held_right_pwm = pwm;
                    end
                    CMD_ROTR:
                    begin
                        issued = 1'b1;
                        st_nxt.held_action    = ACT_ROTR;
                        st_nxt.held_left_pwm  = pwm;
                        st_nxt.held_right_pwm = '0;
                    end
                    default:
                    begin
                        issued = 1'b0;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/drive_safety_supervisor.sv -----
// Drive safety supervisor: input register, decision logic, result register.
// m_tvalid rises once an accepted item has moved from the input register into the result register.
// Throughput: one item per cycle unless m_tready stalls the output; decision state updates as each
// item leaves the input register, so consecutive items see each other's effects.
// Reset (rst_n low, async): config to defaults, link disarmed, held action stop.
// Depends on dss_pkg and dss_decide.
`default_nettype none

module drive_safety_supervisor (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // time_ms[31:0], left_cm[42:32], right_cm[53:43], blocked_side[55:54],
    // cmd[58:56], command_pwm[74:59], zero pad[79:75]
    input  wire logic [dss_pkg::S_TDATA_W-1:0]   s_tdata,
    // has_command
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // action[3:0], left_pwm[13:4], right_pwm[23:14]
    output logic [dss_pkg::M_TDATA_W-1:0]        m_tdata,
    // drive_issued
    output logic                                 m_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dss_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dss_pkg::*;

    dss_cfg_t   cfg_reg;
    dss_state_t st_reg;
    dss_state_t st_next;
    dss_item_t  in_reg;
    logic       in_valid_reg;
    logic       out_valid_reg;
    logic       issued_next;
    logic       issued_reg;
    logic       advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_distance_cm    <= 10'd20;
            cfg_reg.warn_distance_cm   <= 10'd40;
            cfg_reg.sensor_limit_cm    <= 10'd400;
            cfg_reg.cmd_timeout_ms     <= 16'd500;
            cfg_reg.avoid_timeout_ms   <= 16'd2000;
            cfg_reg.avoid_speed        <= 10'd150;
            cfg_reg.pwm_max            <= 10'd255;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MIN_DIST:  cfg_reg.min_distance_cm    <= cfg_data[CFGD_W-1:0];
                REG_WARN_DIST: cfg_reg.warn_distance_cm   <= cfg_data[CFGD_W-1:0];
                REG_SENS_LIM:  cfg_reg.sensor_limit_cm    <= cfg_data[CFGD_W-1:0];
                REG_CMD_TMO:   cfg_reg.cmd_timeout_ms     <= cfg_data[MS_W-1:0];
                REG_AVD_TMO:   cfg_reg.avoid_timeout_ms   <= cfg_data[MS_W-1:0];
                REG_AVD_SPEED: cfg_reg.avoid_speed        <= cfg_data[PWM_W-1:0];
                REG_PWM_MAX:   cfg_reg.pwm_max            <= cfg_data[PWM_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg.time_ms      <= s_tdata[31:0];
            in_reg.left_cm      <= s_tdata[42:32];
            in_reg.right_cm     <= s_tdata[53:43];
            in_reg.blocked_side <= s_tdata[55:54];
            in_reg.cmd          <= s_tdata[58:56];
            in_reg.command_pwm  <= s_tdata[74:59];
            in_reg.has_command  <= s_tuser;
        end
    end

    dss_decide u_decide (
        .cfg    (cfg_reg),
        .item   (in_reg),
        .st_cur (st_reg),
        .st_nxt (st_next),
        .issued (issued_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.link_armed        <= 1'b0;
            st_reg.last_command_time <= '0;
            st_reg.avoiding          <= 1'b0;
            st_reg.avoid_start_time  <= '0;
            st_reg.held_action       <= ACT_STOP;
            st_reg.held_left_pwm     <= '0;
            st_reg.held_right_pwm    <= '0;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            issued_reg <= issued_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = issued_reg;
    assign m_tdata  = {st_reg.held_right_pwm, st_reg.held_left_pwm, st_reg.held_action};

endmodule

`default_nettype wire
